// ===== hdl/scpk_pkg.sv =====
// ----------------------------------------------------------------------------
// scpk_pkg
// Shared types and codes of the size-class pool keep policy block.
// ----------------------------------------------------------------------------
package scpk_pkg;

  localparam int NUM_CLASSES_DEF   = 29;
  localparam int MIN_CLASS_EXP_DEF = 4;
  localparam int HEADER_BYTES_DEF  = 16;
  localparam int COUNT_WIDTH_DEF   = 16;

  localparam int KEEP_RESET = 3;

  typedef enum logic [1:0] {
    CMD_ALLOC_EDGE   = 2'd0,
    CMD_FREE_EDGE    = 2'd1,
    CMD_ALLOC_VERTEX = 2'd2,
    CMD_FREE_VERTEX  = 2'd3
  } scpk_cmd_t;

  typedef enum logic [2:0] {
    ACT_REUSE   = 3'd0,
    ACT_FRESH   = 3'd1,
    ACT_RECLAIM = 3'd2,
    ACT_FAIL    = 3'd3,
    ACT_RETAIN  = 3'd4,
    ACT_RELEASE = 3'd5,
    ACT_VFREE   = 3'd6
  } scpk_act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_WB
  } scpk_state_t;

  typedef struct packed {
    logic free_we;
    logic bt_we;
    logic flush;
  } scpk_mem_ctl_t;

  localparam logic [2:0] ADDR_MIN_KEEP = 3'd0;

endpackage

// ===== hdl/scpk_class.sv =====
// ----------------------------------------------------------------------------
// scpk_class
// Maps a word to its size class: rounded-up power of two of the request
// size (less header for a vertex), or clamped class of a freed edge buffer.
// ----------------------------------------------------------------------------
module scpk_class #(
  parameter int NUM_CLASSES   = scpk_pkg::NUM_CLASSES_DEF,
  parameter int MIN_CLASS_EXP = scpk_pkg::MIN_CLASS_EXP_DEF,
  parameter int HEADER_BYTES  = scpk_pkg::HEADER_BYTES_DEF,
  parameter int CW            = $clog2(NUM_CLASSES)
) (
  input  logic [1:0]    cmd,
  input  logic [31:0]   request_size,
  input  logic [4:0]    freed_class,
  output logic [CW-1:0] cls
);

  logic [31:0] size_v;
  logic [31:0] size_m1;
  logic [5:0]  bit_len;
  logic [5:0]  exp_adj;

  always_comb begin
    if (cmd == scpk_pkg::CMD_ALLOC_VERTEX) begin
      size_v = (request_size > 32'(HEADER_BYTES)) ? request_size - 32'(HEADER_BYTES) : '0;
    end else begin
      size_v = request_size;
    end
    size_m1 = size_v - 32'd1;
    bit_len = '0;
    for (int i = 0; i < 32; i++) begin
      if (size_m1[i]) begin
        bit_len = 6'(i + 1);
      end
    end
    exp_adj = bit_len - 6'(MIN_CLASS_EXP);
    if (cmd == scpk_pkg::CMD_FREE_EDGE) begin
      if (int'(freed_class) > NUM_CLASSES - 1) begin
        cls = CW'(NUM_CLASSES - 1);
      end else begin
        cls = CW'(freed_class);
      end
    end else if (size_v < 32'd2 || int'(bit_len) <= MIN_CLASS_EXP) begin
      cls = '0;
    end else if (int'(exp_adj) > NUM_CLASSES - 1) begin
      cls = CW'(NUM_CLASSES - 1);
    end else begin
      cls = CW'(exp_adj);
    end
  end

endmodule

// ===== hdl/scpk_store.sv =====
// ----------------------------------------------------------------------------
// scpk_store
// Per-class count memories: free counts with a nonzero mask that a flush
// clears at once, and busy and threshold counts with valid bits.
// ----------------------------------------------------------------------------
module scpk_store #(
  parameter int NUM_CLASSES = scpk_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_WIDTH = scpk_pkg::COUNT_WIDTH_DEF,
  parameter int CW          = $clog2(NUM_CLASSES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  scpk_pkg::scpk_mem_ctl_t ctl,
  input  logic [CW-1:0]           rd_c,
  input  logic [CW-1:0]           rd_k,
  input  logic [CW-1:0]           free_wa,
  input  logic [COUNT_WIDTH-1:0]  free_wd,
  input  logic [CW-1:0]           bt_wa,
  input  logic [COUNT_WIDTH-1:0]  busy_wd,
  input  logic [COUNT_WIDTH-1:0]  thr_wd,
  output logic [NUM_CLASSES-1:0]  free_nz,
  output logic [COUNT_WIDTH-1:0]  free_c,
  output logic [COUNT_WIDTH-1:0]  free_k,
  output logic [COUNT_WIDTH-1:0]  busy,
  output logic [COUNT_WIDTH-1:0]  thr
);

  logic [COUNT_WIDTH-1:0]   free_mem [NUM_CLASSES];
  logic [2*COUNT_WIDTH-1:0] bt_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]   bt_vld;
  logic [COUNT_WIDTH-1:0]   free_c_rd;
  logic [COUNT_WIDTH-1:0]   free_k_rd;
  logic [2*COUNT_WIDTH-1:0] bt_rd;
  logic                     c_nz;
  logic                     k_nz;
  logic                     bt_ok;

  always_ff @(posedge clk) begin
    if (ctl.free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    if (ctl.bt_we) begin
      bt_mem[bt_wa] <= {busy_wd, thr_wd};
    end
    free_c_rd <= free_mem[rd_c];
    free_k_rd <= free_mem[rd_k];
    bt_rd     <= bt_mem[rd_c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_nz <= '0;
      bt_vld  <= '0;
      c_nz    <= 1'b0;
      k_nz    <= 1'b0;
      bt_ok   <= 1'b0;
    end else begin
      if (ctl.flush) begin
        free_nz <= '0;
      end else if (ctl.free_we) begin
        free_nz[free_wa] <= (free_wd != '0);
      end
      if (ctl.bt_we) begin
        bt_vld[bt_wa] <= 1'b1;
      end
      c_nz  <= free_nz[rd_c];
      k_nz  <= free_nz[rd_k];
      bt_ok <= bt_vld[rd_c];
    end
  end

  assign free_c = c_nz ? free_c_rd : '0;
  assign free_k = k_nz ? free_k_rd : '0;
  assign busy   = bt_ok ? bt_rd[2*COUNT_WIDTH-1:COUNT_WIDTH] : '0;
  assign thr    = bt_ok ? bt_rd[COUNT_WIDTH-1:0] : '0;

endmodule

// ===== hdl/size_class_pool_keep_policy_top.sv =====
// ----------------------------------------------------------------------------
// size_class_pool_keep_policy_top
// Bookkeeping of a power-of-two size-class buffer pool: reuse, fresh,
// reclaim and keep decisions with per-class counts held in memory.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   cmd, request_size, freed_class,
//                                 first_alloc_ok, retry_alloc_ok
//  out      out_valid / out_stall action, served_class, reclaimed_class,
//                                 pools_flushed, outstanding_count
//  cfg      APB write/read        min_keep_threshold at address 0
//
// An item passes through memory read, decision, divide by three, write back.
// The next word is taken only in the write-back state, once the last is done.
// The count memories share one read/modify/write pass per item.
// Reset needs no clearing pass; reset clears the valid and nonzero bits.
// A stalled result holds write-back until the output register frees up.
// ----------------------------------------------------------------------------
module size_class_pool_keep_policy_top #(
  parameter int NUM_CLASSES   = scpk_pkg::NUM_CLASSES_DEF,
  parameter int MIN_CLASS_EXP = scpk_pkg::MIN_CLASS_EXP_DEF,
  parameter int HEADER_BYTES  = scpk_pkg::HEADER_BYTES_DEF,
  parameter int COUNT_WIDTH   = scpk_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] request_size,
  input  logic [4:0]  freed_class,
  input  logic        first_alloc_ok,
  input  logic        retry_alloc_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [4:0]  served_class,
  output logic [4:0]  reclaimed_class,
  output logic        pools_flushed,
  output logic [31:0] outstanding_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(NUM_CLASSES);
  localparam int W  = COUNT_WIDTH;
  localparam int DN = W + 2;
  localparam int DS = DN + 1;
  localparam longint unsigned DIV_M = ((64'd1 << DS) + 64'd2) / 64'd3;
  localparam logic [W-1:0] CMAX = '1;

  scpk_pkg::scpk_state_t state, state_next;
  scpk_pkg::scpk_mem_ctl_t mem_ctl;

  logic [15:0]       min_keep;
  logic              accept;
  logic              wb_go;
  logic [CW-1:0]     cls_in;

  logic [1:0]        cmd_r;
  logic              first_r;
  logic              retry_r;
  logic [CW-1:0]     cls_r;
  logic [CW-1:0]     k_r;
  logic              found_r;
  logic [CW-1:0]     k_scan;
  logic              found_scan;
  logic [CW:0]       scan_start;

  logic [NUM_CLASSES-1:0] free_nz;
  logic [W-1:0]      free_c, free_k, busy, thr;

  logic [2:0]        act_r;
  logic [W-1:0]      busy_new_r;
  logic [DN-1:0]     num_r;
  logic              smooth_r;
  logic              fwe_r;
  logic [CW-1:0]     fwa_r;
  logic [W-1:0]      fwd_r;
  logic [W-1:0]      free_c_r;
  logic [CW-1:0]     recl_r;
  logic [W-1:0]      q_r;
  logic [2*DN-1:0]   prod;

  logic [2:0]        act_e;
  logic [W-1:0]      busy_e;
  logic              smooth_e;
  logic              fwe_e;
  logic [CW-1:0]     fwa_e;
  logic [W-1:0]      fwd_e;
  logic [W-1:0]      busy_inc, busy_dec;

  logic [W-1:0]      floor_v;
  logic [W-1:0]      t_new;
  logic              release_c;
  logic [2:0]        act_wb;
  logic              out_up, out_down;
  logic [31:0]       out_new;
  logic              flush_wb;
  logic [W-1:0]      free_wd;
  logic [CW-1:0]     free_wa;
  logic [31:0]       outstanding;

  assign pready = 1'b1;
  assign prdata = (paddr == scpk_pkg::ADDR_MIN_KEEP) ? {16'd0, min_keep} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_keep <= 16'(scpk_pkg::KEEP_RESET);
    end else if (psel && penable && pwrite && paddr == scpk_pkg::ADDR_MIN_KEEP) begin
      min_keep <= pwdata[15:0];
    end
  end

  scpk_class #(
    .NUM_CLASSES  (NUM_CLASSES),
    .MIN_CLASS_EXP(MIN_CLASS_EXP),
    .HEADER_BYTES (HEADER_BYTES),
    .CW           (CW)
  ) u_class (
    .cmd         (cmd),
    .request_size(request_size),
    .freed_class (freed_class),
    .cls         (cls_in)
  );

  assign wb_go    = !out_valid || !out_stall;
  assign in_stall = !(state == scpk_pkg::ST_IDLE || (state == scpk_pkg::ST_WB && wb_go));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scpk_pkg::ST_IDLE: if (accept) state_next = scpk_pkg::ST_READ;
      scpk_pkg::ST_READ: state_next = scpk_pkg::ST_EXEC;
      scpk_pkg::ST_EXEC: state_next = scpk_pkg::ST_DIV;
      scpk_pkg::ST_DIV:  state_next = scpk_pkg::ST_WB;
      scpk_pkg::ST_WB: begin
        if (wb_go) begin
          state_next = accept ? scpk_pkg::ST_READ : scpk_pkg::ST_IDLE;
        end
      end
      default: state_next = scpk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd;
      first_r <= first_alloc_ok;
      retry_r <= retry_alloc_ok;
      cls_r   <= cls_in;
    end
  end

  // First class at or above the start that holds a free entry.
  always_comb begin
    scan_start = (cmd_r == scpk_pkg::CMD_ALLOC_EDGE) ? {1'b0, cls_r} + 1'b1 : {1'b0, cls_r};
    k_scan     = '0;
    found_scan = 1'b0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (free_nz[i] && (CW+1)'(i) >= scan_start) begin
        k_scan     = CW'(i);
        found_scan = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == scpk_pkg::ST_READ) begin
      k_r     <= k_scan;
      found_r <= found_scan;
    end
  end

  scpk_store #(
    .NUM_CLASSES(NUM_CLASSES),
    .COUNT_WIDTH(COUNT_WIDTH),
    .CW         (CW)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .rd_c   (cls_r),
    .rd_k   (k_scan),
    .free_wa(free_wa),
    .free_wd(free_wd),
    .bt_wa  (cls_r),
    .busy_wd(busy_new_r),
    .thr_wd (t_new),
    .free_nz(free_nz),
    .free_c (free_c),
    .free_k (free_k),
    .busy   (busy),
    .thr    (thr)
  );

  assign busy_inc = (busy == CMAX) ? busy : busy + 1'b1;
  assign busy_dec = (busy == '0) ? busy : busy - 1'b1;

  always_comb begin
    act_e    = scpk_pkg::ACT_FAIL;
    busy_e   = busy;
    smooth_e = 1'b0;
    fwe_e    = 1'b0;
    fwa_e    = k_r;
    fwd_e    = free_k - 1'b1;
    case (cmd_r)
      scpk_pkg::CMD_ALLOC_EDGE: begin
        if (free_c != '0) begin
          act_e = scpk_pkg::ACT_REUSE;
          fwe_e = 1'b1;
          fwa_e = cls_r;
          fwd_e = free_c - 1'b1;
        end else if (first_r) begin
          act_e = scpk_pkg::ACT_FRESH;
        end else if (found_r) begin
          fwe_e = 1'b1;
          act_e = retry_r ? scpk_pkg::ACT_RECLAIM : scpk_pkg::ACT_FAIL;
        end
        if (act_e != scpk_pkg::ACT_FAIL) begin
          busy_e   = busy_inc;
          smooth_e = 1'b1;
        end
      end
      scpk_pkg::CMD_FREE_EDGE: begin
        act_e    = scpk_pkg::ACT_RETAIN;
        busy_e   = busy_dec;
        smooth_e = 1'b1;
      end
      scpk_pkg::CMD_ALLOC_VERTEX: begin
        if (first_r) begin
          act_e = scpk_pkg::ACT_FRESH;
        end else if (found_r) begin
          fwe_e = 1'b1;
          act_e = retry_r ? scpk_pkg::ACT_RECLAIM : scpk_pkg::ACT_FAIL;
        end
      end
      default: act_e = scpk_pkg::ACT_VFREE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == scpk_pkg::ST_EXEC) begin
      act_r      <= act_e;
      busy_new_r <= busy_e;
      num_r      <= {2'b00, thr} + {2'b00, thr} + {2'b00, busy_e};
      smooth_r   <= smooth_e;
      fwe_r      <= fwe_e;
      fwa_r      <= fwa_e;
      fwd_r      <= fwd_e;
      free_c_r   <= free_c;
      recl_r     <= (act_e == scpk_pkg::ACT_RECLAIM) ? k_r : '0;
    end
  end

  // Divide by three as a multiply by the rounded-up reciprocal.
  assign prod = num_r * DN'(DIV_M);

  always_ff @(posedge clk) begin
    if (state == scpk_pkg::ST_DIV) begin
      q_r <= prod[DS +: W];
    end
  end

  always_comb begin
    if ({17'd0, min_keep} > 33'(CMAX)) begin
      floor_v = CMAX;
    end else begin
      floor_v = W'({17'd0, min_keep});
    end
    t_new     = (q_r < floor_v) ? floor_v : q_r;
    release_c = ({1'b0, busy_new_r} + {1'b0, free_c_r}) > {1'b0, t_new};
    act_wb    = act_r;
    if (cmd_r == scpk_pkg::CMD_FREE_EDGE) begin
      act_wb = release_c ? scpk_pkg::ACT_RELEASE : scpk_pkg::ACT_RETAIN;
    end
    out_up   = (cmd_r == scpk_pkg::CMD_ALLOC_EDGE || cmd_r == scpk_pkg::CMD_ALLOC_VERTEX)
               && act_r != scpk_pkg::ACT_FAIL;
    out_down = (cmd_r == scpk_pkg::CMD_FREE_EDGE || cmd_r == scpk_pkg::CMD_FREE_VERTEX);
    out_new  = outstanding;
    if (out_up && outstanding != '1) begin
      out_new = outstanding + 32'd1;
    end else if (out_down && outstanding != '0) begin
      out_new = outstanding - 32'd1;
    end
    flush_wb = out_down && out_new == '0;
    if (cmd_r == scpk_pkg::CMD_FREE_EDGE) begin
      free_wa = cls_r;
      free_wd = (free_c_r == CMAX) ? free_c_r : free_c_r + 1'b1;
    end else begin
      free_wa = fwa_r;
      free_wd = fwd_r;
    end
    mem_ctl.free_we = (state == scpk_pkg::ST_WB) && wb_go
                      && (fwe_r || (cmd_r == scpk_pkg::CMD_FREE_EDGE && !release_c));
    mem_ctl.bt_we   = (state == scpk_pkg::ST_WB) && wb_go && smooth_r;
    mem_ctl.flush   = (state == scpk_pkg::ST_WB) && wb_go && flush_wb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == scpk_pkg::ST_WB && wb_go) begin
        outstanding <= out_new;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == scpk_pkg::ST_WB && wb_go) begin
      action            <= act_wb;
      served_class      <= (cmd_r == scpk_pkg::CMD_FREE_VERTEX) ? 5'd0 : 5'(cls_r);
      reclaimed_class   <= 5'(recl_r);
      pools_flushed     <= flush_wb;
      outstanding_count <= out_new;
    end
  end

endmodule

// ===== hdl/scpk_checker.sv =====
// ----------------------------------------------------------------------------
// scpk_checker
// Port-level checks of the size-class pool keep policy block.
// ----------------------------------------------------------------------------
module scpk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  action,
  input logic [4:0]  reclaimed_class,
  input logic        pools_flushed,
  input logic [31:0] outstanding_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(action) && $stable(outstanding_count))
    else $error("stalled result word changed");

  a_flush_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pools_flushed |-> outstanding_count == 32'd0)
    else $error("flush reported with buffers outstanding");

  a_reclaim_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != scpk_pkg::ACT_RECLAIM |-> reclaimed_class == 5'd0)
    else $error("reclaimed class set without a reclaim");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while the first is in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind size_class_pool_keep_policy_top scpk_checker u_scpk_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .action           (action),
  .reclaimed_class  (reclaimed_class),
  .pools_flushed    (pools_flushed),
  .outstanding_count(outstanding_count)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the size-class pool keep policy block against a behavioral copy of
// its bookkeeping. Words go in over a valid/stall channel and each result
// word is compared field by field with the oldest predicted result, under
// several idle and stall patterns and several keep-threshold floors.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NCLS = 29;
  localparam logic [16:0] CNT_MAX = 17'h0FFFF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  act;
    logic [4:0]  served;
    logic [4:0]  reclaimed;
    logic        flushed;
    logic [31:0] outstanding;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = scpk_pkg::CMD_ALLOC_EDGE;
  logic [31:0] request_size = 32'd1;
  logic [4:0] freed_class = 5'd0;
  logic first_alloc_ok = 1'b0;
  logic retry_alloc_ok = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] action;
  logic [4:0] served_class;
  logic [4:0] reclaimed_class;
  logic pools_flushed;
  logic [31:0] outstanding_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = scpk_pkg::ADDR_MIN_KEEP;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  size_class_pool_keep_policy_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [15:0] free_cnt [NCLS];
  logic [15:0] busy_cnt [NCLS];
  logic [15:0] keep_thr [NCLS];
  logic [31:0] handed_out;
  logic [15:0] keep_floor;
  pool_result_t expected_results [$];
  int errors = 0;
  int sent_items = 0;
  int checked_words = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  function automatic logic [4:0] size_class(input logic [32:0] n);
    int e;
    logic [32:0] v;
    e = 0;
    if (n < 2) return 5'd0;
    v = n - 33'd1;
    while (v != 0) begin
      v = v >> 1;
      e++;
    end
    if (e <= 4) return 5'd0;
    e = e - 4;
    if (e > NCLS - 1) e = NCLS - 1;
    return e[4:0];
  endfunction

  function automatic void smooth_keep(input int c);
    logic [17:0] t;
    t = ((18'(keep_thr[c]) << 1) + 18'(busy_cnt[c])) / 18'd3;
    if (t < 18'(keep_floor)) t = 18'(keep_floor);
    keep_thr[c] = t[15:0];
  endfunction

  function automatic bit reclaim_scan(input int start, output int found);
    for (int k = start; k < NCLS; k++) begin
      if (free_cnt[k] != 0) begin
        free_cnt[k]--;
        found = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit release_outstanding();
    if (handed_out != 0) handed_out--;
    if (handed_out == 0) begin
      foreach (free_cnt[i]) free_cnt[i] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void take_outstanding();
    if (handed_out != 32'hFFFF_FFFF) handed_out++;
  endfunction

  function automatic pool_result_t predict_pool(input logic [1:0] c_cmd,
      input logic [31:0] sz, input logic [4:0] fc, input bit f_ok, input bit r_ok);
    pool_result_t r;
    int c;
    int k;
    bit ok;
    r = '0;
    r.act = scpk_pkg::ACT_FAIL;
    k = 0;
    case (c_cmd)
      scpk_pkg::CMD_ALLOC_EDGE: begin
        c = int'(size_class({1'b0, sz}));
        r.served = c[4:0];
        ok = 1'b1;
        if (free_cnt[c] != 0) begin
          free_cnt[c]--;
          r.act = scpk_pkg::ACT_REUSE;
        end else if (f_ok) begin
          r.act = scpk_pkg::ACT_FRESH;
        end else if (reclaim_scan(c + 1, k) && r_ok) begin
          r.act = scpk_pkg::ACT_RECLAIM;
          r.reclaimed = k[4:0];
        end else begin
          ok = 1'b0;
        end
        if (ok) begin
          if (busy_cnt[c] != CNT_MAX[15:0]) busy_cnt[c]++;
          smooth_keep(c);
          take_outstanding();
        end
      end
      scpk_pkg::CMD_FREE_EDGE: begin
        c = (int'(fc) > NCLS - 1) ? NCLS - 1 : int'(fc);
        r.served = c[4:0];
        if (busy_cnt[c] != 0) busy_cnt[c]--;
        smooth_keep(c);
        if (17'(busy_cnt[c]) + 17'(free_cnt[c]) > 17'(keep_thr[c])) begin
          r.act = scpk_pkg::ACT_RELEASE;
        end else begin
          r.act = scpk_pkg::ACT_RETAIN;
          if (free_cnt[c] != CNT_MAX[15:0]) free_cnt[c]++;
        end
        r.flushed = release_outstanding();
      end
      scpk_pkg::CMD_ALLOC_VERTEX: begin
        c = (sz > 32'd16) ? int'(size_class({1'b0, sz - 32'd16})) : 0;
        r.served = c[4:0];
        if (f_ok) begin
          r.act = scpk_pkg::ACT_FRESH;
          take_outstanding();
        end else if (reclaim_scan(c, k) && r_ok) begin
          r.act = scpk_pkg::ACT_RECLAIM;
          r.reclaimed = k[4:0];
          take_outstanding();
        end
      end
      default: begin
        r.act = scpk_pkg::ACT_VFREE;
        r.flushed = release_outstanding();
      end
    endcase
    r.outstanding = handed_out;
    return r;
  endfunction

  // The word stays valid after acceptance until the next send or an explicit drop.
  task automatic send_word(input logic [1:0] c_cmd, input logic [31:0] sz,
      input logic [4:0] fc, input bit f_ok, input bit r_ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c_cmd;
    request_size <= sz;
    freed_class <= fc;
    first_alloc_ok <= f_ok;
    retry_alloc_ok <= r_ok;
    expected_results.push_back(predict_pool(c_cmd, sz, fc, f_ok, r_ok));
    sent_items++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_keep_floor(input logic [15:0] v);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= scpk_pkg::ADDR_MIN_KEEP;
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    keep_floor = v;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      pool_result_t got;
      pool_result_t want;
      got = {action, served_class, reclaimed_class, pools_flushed, outstanding_count};
      checked_words++;
      if (expected_results.size() == 0) begin
        $error("unexpected result word %p", got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.act != want.act) begin
          $error("action: expected %0d, got %0d", want.act, got.act);
          errors++;
        end
        if (got.served != want.served) begin
          $error("served_class: expected %0d, got %0d", want.served, got.served);
          errors++;
        end
        if (got.reclaimed != want.reclaimed) begin
          $error("reclaimed_class: expected %0d, got %0d", want.reclaimed, got.reclaimed);
          errors++;
        end
        if (got.flushed != want.flushed) begin
          $error("pools_flushed: expected %0d, got %0d", want.flushed, got.flushed);
          errors++;
        end
        if (got.outstanding != want.outstanding) begin
          $error("outstanding_count: expected %0d, got %0d",
                 want.outstanding, got.outstanding);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] rand_size();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom();
    if (sel == 1) return $urandom_range(32, 0);
    return $urandom_range(1 << $urandom_range(12, 1), 1);
  endfunction

  task automatic test_directed();
    send_word(scpk_pkg::CMD_FREE_VERTEX, 32'd0, 5'd0, 1'b0, 1'b0);
    send_word(scpk_pkg::CMD_FREE_EDGE, 32'd0, 5'd31, 1'b0, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_EDGE, 32'd0, 5'd0, 1'b0, 1'b1);
    send_word(scpk_pkg::CMD_ALLOC_EDGE, 32'd1, 5'd0, 1'b1, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_EDGE, 32'd17, 5'd0, 1'b1, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_EDGE, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_EDGE, 32'h8000_0001, 5'd0, 1'b1, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_VERTEX, 32'd16, 5'd0, 1'b1, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_VERTEX, 32'd49, 5'd0, 1'b1, 1'b0);
    send_word(scpk_pkg::CMD_FREE_EDGE, 32'd0, 5'd0, 1'b0, 1'b0);
    send_word(scpk_pkg::CMD_FREE_EDGE, 32'd0, 5'd28, 1'b0, 1'b0);
    send_word(scpk_pkg::CMD_FREE_EDGE, 32'd0, 5'd1, 1'b0, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_EDGE, 32'd16, 5'd0, 1'b0, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_EDGE, 32'd2, 5'd0, 1'b0, 1'b1);
    send_word(scpk_pkg::CMD_ALLOC_EDGE, 32'd2, 5'd0, 1'b0, 1'b0);
    send_word(scpk_pkg::CMD_ALLOC_VERTEX, 32'd20, 5'd0, 1'b0, 1'b1);
    send_word(scpk_pkg::CMD_ALLOC_VERTEX, 32'd20, 5'd0, 1'b0, 1'b0);
    send_word(scpk_pkg::CMD_FREE_EDGE, 32'd0, 5'd2, 1'b1, 1'b1);
    send_word(scpk_pkg::CMD_FREE_VERTEX, 32'hFFFF_FFFF, 5'd31, 1'b1, 1'b1);
    send_word(scpk_pkg::CMD_FREE_VERTEX, 32'd0, 5'd0, 1'b0, 1'b0);
  endtask

  // Mostly balanced allocate/free runs so the free lists fill and get reused.
  task automatic test_random(input int n);
    logic [1:0] c;
    for (int i = 0; i < n; i++) begin
      c = 2'($urandom_range(3));
      if ($urandom_range(9) < 7 && (c == scpk_pkg::CMD_FREE_VERTEX) && handed_out < 3)
        c = scpk_pkg::CMD_ALLOC_EDGE;
      send_word(c, rand_size(),
                ($urandom_range(19) == 0) ? 5'($urandom()) : 5'($urandom_range(10)),
                $urandom_range(2) == 0, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_floors();
    write_keep_floor(16'd0);
    test_random(300);
    write_keep_floor(16'hFFFF);
    test_random(300);
    write_keep_floor(16'($urandom()));
    test_random(200);
    write_keep_floor(16'd3);
  endtask

  task automatic test_pressure();
    send_idle_pct = 77;
    test_random(250);
    send_idle_pct = 0;
    stall_pct = 77;
    test_random(250);
    send_idle_pct = 14;
    stall_pct = 14;
    test_random(250);
    send_idle_pct = 0;
    stall_pct = 0;
    test_random(280);
  endtask

  initial begin
    foreach (free_cnt[i]) begin
      free_cnt[i] = '0;
      busy_cnt[i] = '0;
      keep_thr[i] = '0;
    end
    handed_out = '0;
    keep_floor = 16'(scpk_pkg::KEEP_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_floors();
    test_pressure();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d input words and %0d result words over four keep floors",
             sent_items, checked_words);
    $display("and four idle/stall patterns.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
